// ===== sv/pfe_pkg.sv =====
// package: types, codes and constants shared by the format engine modules
`default_nettype none

package pfe_pkg;

    typedef enum logic [1:0] {
        PH_LIT,
        PH_FLAGS,
        PH_WIDTH,
        PH_MOD
    } t_phase;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_PLAN,
        ST_SGN_PRE,
        ST_PAD_L,
        ST_SGN,
        ST_DIG,
        ST_PAD_R
    } t_state;

    typedef enum logic [1:0] {
        RDX_DEC,
        RDX_OCT,
        RDX_HEX,
        RDX_CHR
    } t_radix;

    typedef enum logic [1:0] {
        SEL_SGN,
        SEL_PAD_L,
        SEL_DIG,
        SEL_PAD_R
    } t_esel;

    typedef struct packed {
        logic  in_ready;
        logic  div_step;
        logic  plan;
        logic  emit;
        t_esel sel;
    } t_cmd;

    typedef struct packed {
        logic in_valid;
        logic conv;
        logic conv_chr;
        logic out_free;
        logic div_done;
        logic pre_sgn;
        logic mid_sgn;
        logic pad_l;
        logic pad_r;
        logic pad_one;
        logic dig_one;
    } t_stat;

    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_F     = 8'h46;
    localparam logic [7:0] CH_N     = 8'h4e;
    localparam logic [7:0] CH_L     = 8'h6c;
    localparam logic [7:0] CH_H     = 8'h68;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_P     = 8'h70;
    localparam logic [7:0] CH_LN    = 8'h6e;
    localparam logic [7:0] CH_D     = 8'h64;
    localparam logic [7:0] CH_I     = 8'h69;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_O     = 8'h6f;
    localparam logic [7:0] CH_C     = 8'h63;

    localparam logic [31:0] RECIP_10  = 32'hcccc_cccd;
    localparam int          DIV10_SHR = 35;

endpackage

`default_nettype wire

// ===== sv/pfe_if.sv =====
// interfaces: format character request channel and output character channel
`default_nettype none

interface pfe_in_if;
    logic        valid;
    logic        ready;
    logic        new_format;
    logic [7:0]  fmt_char;
    logic [31:0] arg_value;

    modport source (output valid, new_format, fmt_char, arg_value, input ready);
    modport sink (input valid, new_format, fmt_char, arg_value, output ready);
endinterface

interface pfe_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_char;
    logic [15:0] char_count;
    logic        last;

    modport source (output valid, out_char, char_count, last, input ready);
    modport sink (input valid, out_char, char_count, last, output ready);
endinterface

`default_nettype wire

// ===== sv/printf_format_engine_top.sv =====
// top level: printf style format engine, one format character per request
// A request carries one format character and a 32-bit argument. Ordinary
// characters and %% give one output character in the cycle after acceptance.
// Flags, width and modifier characters give no output. A conversion first
// extracts one digit per cycle (up to 10 digits for decimal, 11 for octal,
// 8 for hex, none for %c), then plans the padding, then emits one character
// per cycle, max(width, digits + sign) characters in all; the output register
// and the digit loop set the rate. No request is taken while a conversion
// is running. Output stalls hold the engine.
`default_nettype none

module printf_format_engine_top
    import pfe_pkg::*;
#(
    parameter int MAX_FIELD_WIDTH    = 63,
    parameter int DIGIT_BUFFER_DEPTH = 16
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    pfe_in_if.sink     i_in,
    pfe_out_if.source  o_out
);

    t_cmd  cmd;
    t_stat stat;

    pfe_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    pfe_dp #(
        .MAX_FIELD_WIDTH    (MAX_FIELD_WIDTH),
        .DIGIT_BUFFER_DEPTH (DIGIT_BUFFER_DEPTH)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .i_in    (i_in),
        .o_out   (o_out)
    );

    // emission only into a free output slot
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> stat.out_free)
        else $error("emit into occupied output register");

    // no request taken during a conversion
    a_ready_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.in_ready |-> (!cmd.emit && !cmd.div_step && !cmd.plan))
        else $error("request accepted while converting");

    // counter advances by one per new character within a format
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |=> (o_out.char_count == $past(o_out.char_count)
                      + 16'd1) || !$past(o_out.valid))
        else $error("character count did not step");

endmodule

`default_nettype wire

// ===== sv/pfe_ctrl.sv =====
// controller: sequences digit extraction and the emission phases
`default_nettype none

module pfe_ctrl
    import pfe_pkg::*;
(
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.sel = SEL_SGN;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.in_ready = i_stat.out_free;
                if (i_stat.in_valid && i_stat.out_free && i_stat.conv) begin
                    n_state = i_stat.conv_chr ? ST_PLAN : ST_DIV;
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_done) begin
                    n_state = ST_PLAN;
                end
            end
            ST_PLAN: begin
                o_cmd.plan = 1'b1;
                if (i_stat.pre_sgn) begin
                    n_state = ST_SGN_PRE;
                end else if (i_stat.pad_l) begin
                    n_state = ST_PAD_L;
                end else if (i_stat.mid_sgn) begin
                    n_state = ST_SGN;
                end else begin
                    n_state = ST_DIG;
                end
            end
            ST_SGN_PRE: begin
                o_cmd.sel = SEL_SGN;
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state = i_stat.pad_l ? ST_PAD_L : ST_DIG;
                end
            end
            ST_PAD_L: begin
                o_cmd.sel = SEL_PAD_L;
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_stat.pad_one) begin
                        n_state = i_stat.mid_sgn ? ST_SGN : ST_DIG;
                    end
                end
            end
            ST_SGN: begin
                o_cmd.sel = SEL_SGN;
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state = ST_DIG;
                end
            end
            ST_DIG: begin
                o_cmd.sel = SEL_DIG;
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_stat.dig_one) begin
                        n_state = i_stat.pad_r ? ST_PAD_R : ST_IDLE;
                    end
                end
            end
            ST_PAD_R: begin
                o_cmd.sel = SEL_PAD_R;
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_stat.pad_one) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/pfe_dp.sv =====
// datapath: format parser, digit extraction, digit buffer and output register
`default_nettype none

module pfe_dp
    import pfe_pkg::*;
#(
    parameter int MAX_FIELD_WIDTH    = 63,
    parameter int DIGIT_BUFFER_DEPTH = 16
) (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  t_cmd           i_cmd,
    output t_stat          o_stat,
    pfe_in_if.sink         i_in,
    pfe_out_if.source      o_out
);

    localparam int IDX_W = $clog2(DIGIT_BUFFER_DEPTH);

    // parse state
    t_phase      r_phase;
    logic        r_lj;
    logic        r_lz;
    logic        r_f32;
    logic        r_f16;
    logic [5:0]  r_fw;
    logic [15:0] r_count;

    // conversion working registers
    logic [31:0]      r_val;
    t_radix           r_radix;
    logic             r_upper;
    logic             r_neg;
    logic             r_clj;
    logic             r_clz;
    logic [5:0]       r_width;
    logic [IDX_W-1:0] r_nd;
    logic [7:0]       r_dig [DIGIT_BUFFER_DEPTH];
    logic [5:0]       r_pad;
    logic [5:0]       r_left;

    // output register
    logic        r_ovalid;
    logic [7:0]  r_ochar;
    logic [15:0] r_ocount;
    logic        r_olast;

    // parser results
    t_phase      n_phase;
    logic        n_lj;
    logic        n_lz;
    logic        n_f32;
    logic        n_f16;
    logic [5:0]  n_fw;
    logic        lit_emit;
    logic        conv;
    logic        conv_chr;
    t_radix      conv_radix;
    logic        conv_upper;
    logic        conv_sg;
    logic        go_width;
    logic        go_mod;
    logic [9:0]  w10;
    logic [15:0] cnt_base;
    logic [7:0]  c;
    logic        accept;

    // conversion setup
    logic [31:0] vs;
    logic        vneg;
    logic [31:0] vmag;

    // digit step
    logic [63:0] prod;
    logic [31:0] q;
    logic [31:0] q10;
    logic [3:0]  rem;
    logic [7:0]  dchar;

    logic [5:0]  actual;
    logic [5:0]  live_pad;
    logic [7:0]  ech;
    logic        out_free;

    assign c        = i_in.fmt_char;
    assign out_free = !r_ovalid || o_out.ready;
    assign accept   = i_in.valid && i_cmd.in_ready;
    assign i_in.ready = i_cmd.in_ready;
    assign cnt_base = i_in.new_format ? 16'd0 : r_count;

    always_comb begin
        n_phase    = i_in.new_format ? PH_LIT : r_phase;
        n_lj       = i_in.new_format ? 1'b0 : r_lj;
        n_lz       = i_in.new_format ? 1'b0 : r_lz;
        n_f32      = i_in.new_format ? 1'b0 : r_f32;
        n_f16      = i_in.new_format ? 1'b0 : r_f16;
        n_fw       = i_in.new_format ? 6'd0 : r_fw;
        lit_emit   = 1'b0;
        conv       = 1'b0;
        conv_chr   = 1'b0;
        conv_radix = RDX_DEC;
        conv_upper = 1'b0;
        conv_sg    = 1'b0;
        go_width   = 1'b0;
        go_mod     = 1'b0;
        w10        = '0;
        case (n_phase)
            PH_LIT: begin
                if (c != CH_PCT) begin
                    lit_emit = 1'b1;
                end else begin
                    n_phase = PH_FLAGS;
                end
            end
            PH_FLAGS: begin
                if (c == CH_PCT) begin
                    lit_emit = 1'b1;
                    n_phase  = PH_LIT;
                    n_lj = 1'b0; n_lz = 1'b0; n_f32 = 1'b0; n_f16 = 1'b0;
                    n_fw = 6'd0;
                end else if (c == CH_MINUS) begin
                    if (n_lj) begin
                        n_phase = PH_LIT;
                        n_lj = 1'b0; n_lz = 1'b0; n_f32 = 1'b0; n_f16 = 1'b0;
                        n_fw = 6'd0;
                    end else begin
                        n_lj = 1'b1;
                    end
                end else begin
                    n_phase = PH_WIDTH;
                    if (c == CH_ZERO) begin
                        n_lz = 1'b1;
                    end else begin
                        go_width = 1'b1;
                    end
                end
            end
            PH_WIDTH: go_width = 1'b1;
            default:  go_mod = 1'b1;
        endcase
        if (go_width) begin
            if (c >= CH_ZERO && c <= CH_NINE) begin
                w10 = 10'({4'd0, n_fw} * 10'd10) + {2'd0, c - CH_ZERO};
                n_fw = (w10 > 10'(MAX_FIELD_WIDTH)) ? 6'(MAX_FIELD_WIDTH) : w10[5:0];
            end else begin
                go_mod = 1'b1;
            end
        end
        if (go_mod) begin
            n_phase = PH_MOD;
            if (c == CH_L) begin
                n_f32 = 1'b1;
            end else if (c == CH_H) begin
                n_f16 = 1'b1;
            end else if (c != CH_F && c != CH_N) begin
                case (c)
                    CH_UX: begin
                        conv = 1'b1; conv_radix = RDX_HEX; conv_upper = 1'b1;
                    end
                    CH_X, CH_P, CH_LN: begin
                        conv = 1'b1; conv_radix = RDX_HEX;
                    end
                    CH_D, CH_I: begin
                        conv = 1'b1; conv_radix = RDX_DEC; conv_sg = 1'b1;
                    end
                    CH_U: begin
                        conv = 1'b1; conv_radix = RDX_DEC;
                    end
                    CH_O: begin
                        conv = 1'b1; conv_radix = RDX_OCT;
                    end
                    CH_C: begin
                        conv = 1'b1; conv_radix = RDX_CHR; conv_chr = 1'b1;
                    end
                    default: conv = 1'b0;
                endcase
                n_phase = PH_LIT;
                n_lj = 1'b0; n_lz = 1'b0; n_f32 = 1'b0; n_f16 = 1'b0;
                n_fw = 6'd0;
            end
        end
    end

    // short values take bit 15 as sign in signed conversions and are zero-extended otherwise, long wins over short
    always_comb begin
        if (r_f16 && !r_f32) begin
            vs = conv_sg ? {{16{i_in.arg_value[15]}}, i_in.arg_value[15:0]}
                         : {16'd0, i_in.arg_value[15:0]};
        end else begin
            vs = i_in.arg_value;
        end
        vneg = conv_sg && vs[31];
        vmag = vneg ? (32'd0 - vs) : vs;
    end

    always_comb begin
        prod = {32'd0, r_val} * {32'd0, RECIP_10};
        q    = r_val;
        rem  = '0;
        case (r_radix)
            RDX_OCT: begin
                q   = {3'd0, r_val[31:3]};
                rem = {1'b0, r_val[2:0]};
            end
            RDX_HEX: begin
                q   = {4'd0, r_val[31:4]};
                rem = r_val[3:0];
            end
            default: begin
                q   = 32'(prod >> DIV10_SHR);
                rem = 4'(r_val - ((q << 3) + (q << 1)));
            end
        endcase
        q10 = q;
        if (rem < 4'd10) begin
            dchar = CH_ZERO + {4'd0, rem};
        end else begin
            dchar = (r_upper ? CH_UA : CH_LA) + {4'd0, rem} - 8'd10;
        end
    end

    assign actual   = 6'(r_nd) + {5'd0, r_neg};
    assign live_pad = (r_width > actual) ? (r_width - actual) : 6'd0;

    always_comb begin
        case (i_cmd.sel)
            SEL_PAD_L: ech = r_clz ? CH_ZERO : CH_SPACE;
            SEL_DIG:   ech = r_dig[r_nd - 1'b1];
            SEL_PAD_R: ech = CH_SPACE;
            default:   ech = CH_MINUS;
        endcase
    end

    always_comb begin
        o_stat          = '0;
        o_stat.in_valid = i_in.valid;
        o_stat.conv     = conv;
        o_stat.conv_chr = conv_chr;
        o_stat.out_free = out_free;
        o_stat.div_done = (q10 == 32'd0);
        o_stat.pre_sgn  = r_neg && r_clz;
        o_stat.mid_sgn  = r_neg && !r_clz;
        o_stat.pad_l    = !r_clj && (live_pad != 6'd0);
        o_stat.pad_r    = r_clj && (r_pad != 6'd0);
        o_stat.pad_one  = (r_pad == 6'd1);
        o_stat.dig_one  = (r_nd == IDX_W'(1));
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_LIT;
            r_lj     <= 1'b0;
            r_lz     <= 1'b0;
            r_f32    <= 1'b0;
            r_f16    <= 1'b0;
            r_fw     <= '0;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (out_free) begin
                r_ovalid <= 1'b0;
            end
            if (accept) begin
                r_phase <= n_phase;
                r_lj    <= n_lj;
                r_lz    <= n_lz;
                r_f32   <= n_f32;
                r_f16   <= n_f16;
                r_fw    <= n_fw;
                r_count <= lit_emit ? cnt_base + 16'd1 : cnt_base;
                if (lit_emit) begin
                    r_ovalid <= 1'b1;
                end
            end else if (i_cmd.emit) begin
                r_count  <= r_count + 16'd1;
                r_ovalid <= 1'b1;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ochar  <= c;
            r_ocount <= cnt_base + 16'd1;
            r_olast  <= 1'b1;
            if (conv) begin
                r_radix <= conv_radix;
                r_upper <= conv_upper;
                r_width <= i_in.new_format ? 6'd0 : r_fw;
                r_clj   <= i_in.new_format ? 1'b0 : r_lj;
                r_clz   <= (i_in.new_format || conv_chr) ? 1'b0 : r_lz;
                if (conv_chr) begin
                    r_neg    <= 1'b0;
                    r_nd     <= IDX_W'(1);
                    r_dig[0] <= i_in.arg_value[7:0];
                end else begin
                    r_neg <= vneg;
                    r_val <= vmag;
                    r_nd  <= '0;
                end
            end
        end else if (i_cmd.div_step) begin
            r_val <= q10;
            if (r_nd < IDX_W'(DIGIT_BUFFER_DEPTH - 1)) begin
                r_dig[r_nd] <= dchar;
                r_nd        <= r_nd + 1'b1;
            end
        end else if (i_cmd.plan) begin
            r_pad  <= live_pad;
            r_left <= live_pad + actual;
        end else if (i_cmd.emit) begin
            r_ochar  <= ech;
            r_ocount <= r_count + 16'd1;
            r_olast  <= (r_left == 6'd1);
            r_left   <= r_left - 6'd1;
            if (i_cmd.sel == SEL_PAD_L || i_cmd.sel == SEL_PAD_R) begin
                r_pad <= r_pad - 6'd1;
            end
            if (i_cmd.sel == SEL_DIG) begin
                r_nd <= r_nd - 1'b1;
            end
        end
    end

    assign o_out.valid      = r_ovalid;
    assign o_out.out_char   = r_ochar;
    assign o_out.char_count = r_ocount;
    assign o_out.last       = r_olast;

endmodule

`default_nettype wire
